// ===== rtl/weekly_event_schedule_table_defines.svh =====
// assertion macros shared by the weekly event schedule table rtl
// no dependencies; included by the files that carry assertions
`ifndef WEEKLY_EVENT_SCHEDULE_TABLE_DEFINES_SVH
`define WEEKLY_EVENT_SCHEDULE_TABLE_DEFINES_SVH

// clocked property, disabled while reset is asserted
`define WEST_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// condition that must never be seen at a clock edge
`define WEST_NEVER(lbl, clk, rstn, cond, msg) \
	`WEST_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

// ===== rtl/west_pkg.sv =====
// types and constants of the weekly event schedule table
// no dependencies; imported by the top level and the testbench
package west_pkg;

	// request opcodes
	localparam logic [1:0] OP_ON     = 2'd0;
	localparam logic [1:0] OP_OFF    = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_TICK   = 2'd3;

	// status codes of a schedule response
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_BAD  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// response kinds
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_CMD    = 1'b1;

	// day codes of single days and of day groups
	localparam logic [3:0] DAY_SUNDAY   = 4'd0;
	localparam logic [3:0] DAY_MONDAY   = 4'd1;
	localparam logic [3:0] DAY_FRIDAY   = 4'd5;
	localparam logic [3:0] DAY_SATURDAY = 4'd6;
	localparam logic [3:0] DAY_EVERY    = 4'd7;
	localparam logic [3:0] DAY_WEEKDAYS = 4'd8;
	localparam logic [3:0] DAY_WEEKEND  = 4'd9;

	// register index, taken from paddr bit 2
	localparam logic REG_LIGHT_ID_LIMIT = 1'b0;
	localparam logic [6:0] LIMIT_RESET  = 7'd32;

	typedef struct packed {
		logic [1:0]        opcode;
		logic signed [7:0] light_id;
		logic [3:0]        day;
		logic [10:0]       minute;
	} west_req_t;

	typedef struct packed {
		logic       kind;
		logic [1:0] status;
		logic [6:0] cmd_light;
		logic       turn_on;
		logic       last;
	} west_rsp_t;

	typedef struct packed {
		logic [6:0]  light;
		logic [3:0]  day;
		logic [10:0] minute;
		logic        turn_on;
	} west_entry_t;

endpackage

// ===== rtl/west_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies; read data holds while no read is issued
module west_ram #(
	parameter int WIDTH = 23,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/weekly_event_schedule_table.sv =====
// weekly event schedule table, top level
// depends on west_pkg, west_ram and weekly_event_schedule_table_defines.svh
//
// usage
// - req channel (req_valid, req_stall, req): one request per transaction,
//   opcode schedule-on, schedule-off, remove or minute tick
// - rsp channel (rsp_valid, rsp_stall, rsp): schedule requests answer with
//   one status transaction; a tick answers with one command per due entry
//   in slot order, last set on the final one; remove and an idle tick
//   answer with nothing
// - apb port holds light_id_limit at byte address 0
// timing
// - one request at a time; req_stall is high from acceptance until the
//   last response has moved into the output register
// - schedule: a walk over the valid bits, one slot per cycle, to find the
//   lowest free slot
// - remove and tick: a scan through the single read port of the entry ram,
//   one slot per cycle unless a tick hit waits on a stalled rsp channel
// - a held command waits for the next hit to learn its last flag, so a
//   stalled receiver pauses the scan; nothing is lost or repeated
// reset
// - valid bits clear at once in flip-flops, limit returns to 32,
//   no clearing pass over the ram is needed
module weekly_event_schedule_table
	import west_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        req_valid,
	output logic        req_stall,
	input  west_req_t   req,
	// response channel
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output west_rsp_t   rsp,
	// apb configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	`include "weekly_event_schedule_table_defines.svh"

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);
	localparam int EW = $bits(west_entry_t);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FIND  = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_t;

	// does entry day code fire on today's weekday
	function automatic logic covers_today(input logic [3:0] code, input logic [3:0] today);
		logic hit;
		hit = (code == DAY_EVERY) || (code == today);
		if (code == DAY_WEEKEND && (today == DAY_SUNDAY || today == DAY_SATURDAY)) begin
			hit = 1'b1;
		end
		if (code == DAY_WEEKDAYS && today >= DAY_MONDAY && today <= DAY_FRIDAY) begin
			hit = 1'b1;
		end
		return hit;
	endfunction

	// control state
	state_t              state_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [IW-1:0]       idx_q;          // find slot, or next scan read address
	logic                issue_done_q;   // every slot read has been issued
	logic                s1_valid_q;     // ram read data is live
	logic                pend_valid_q;   // a response is held back
	logic                rsp_valid_q;
	logic [6:0]          limit_q;

	// payload
	logic [1:0]          op_q;
	logic [7:0]          key_light_q;
	logic [3:0]          key_day_q;
	logic [10:0]         key_min_q;
	logic [IW-1:0]       idx_s1;
	west_rsp_t           pend_q;
	west_rsp_t           rsp_q;

	// ram
	logic                ram_we;
	logic                ram_re;
	logic [EW-1:0]       ram_rdata;
	west_entry_t         ent;
	west_entry_t         wr_ent;

	logic accept;
	logic rsp_free;
	logic id_bad;
	logic ent_valid;
	logic min_eq;
	logic rm_hit;
	logic tk_hit;
	logic scan_adv;
	logic find_free;
	logic drain_push;
	logic succ_push;
	logic cfg_wr;

	west_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_DEPTH)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (wr_ent),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// handshake helpers
	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	// negative ids and ids at or above the limit are rejected
	assign id_bad    = req.light_id[7] || (req.light_id[6:0] >= limit_q);

	// compare stage on ram read data
	assign ent       = west_entry_t'(ram_rdata);
	assign ent_valid = valid_q[idx_s1];
	assign min_eq    = (ent.minute == key_min_q);
	// a negative key never matches the 7-bit stored id
	assign rm_hit    = (state_q == ST_SCAN) && s1_valid_q && (op_q != OP_TICK) && ent_valid
		&& ({1'b0, ent.light} == key_light_q) && (ent.day == key_day_q) && min_eq;
	assign tk_hit    = (state_q == ST_SCAN) && s1_valid_q && (op_q == OP_TICK) && ent_valid
		&& covers_today(ent.day, key_day_q) && min_eq;
	// a new hit can only be taken once the held one has somewhere to go
	assign scan_adv  = !(tk_hit && pend_valid_q && !rsp_free);
	assign succ_push = tk_hit && pend_valid_q && rsp_free;
	assign drain_push = (state_q == ST_DRAIN) && pend_valid_q && rsp_free;

	// find stage works on the valid flops
	assign find_free = !valid_q[idx_q];
	assign ram_we    = (state_q == ST_FIND) && find_free;
	assign ram_re    = (state_q == ST_SCAN) && scan_adv && !issue_done_q;

	always_comb begin
		wr_ent.light   = key_light_q[6:0];
		wr_ent.day     = key_day_q;
		wr_ent.minute  = key_min_q;
		wr_ent.turn_on = (op_q == OP_ON);
	end

	// configuration
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_LIGHT_ID_LIMIT);
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_LIGHT_ID_LIMIT) ? {25'd0, limit_q} : 32'd0;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			idx_q        <= '0;
			issue_done_q <= 1'b0;
			s1_valid_q   <= 1'b0;
			pend_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
			limit_q      <= LIMIT_RESET;
		end else begin
			if (cfg_wr) begin
				limit_q <= pwdata[6:0];
			end

			// output register: refill from the held response, else drain when taken
			if (drain_push || succ_push) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q        <= '0;
						issue_done_q <= 1'b0;
						s1_valid_q   <= 1'b0;
						if (req.opcode == OP_ON || req.opcode == OP_OFF) begin
							if (id_bad) begin
								pend_valid_q <= 1'b1;
								state_q      <= ST_DRAIN;
							end else begin
								state_q <= ST_FIND;
							end
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_FIND: begin
					if (find_free) begin
						valid_q[idx_q] <= 1'b1;
						pend_valid_q   <= 1'b1;
						state_q        <= ST_DRAIN;
					end else if (idx_q == LAST_IDX) begin
						pend_valid_q <= 1'b1;
						state_q      <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_SCAN: begin
					if (rm_hit) begin
						valid_q[idx_s1] <= 1'b0;
					end
					if (scan_adv) begin
						if (tk_hit) begin
							pend_valid_q <= 1'b1;
						end
						s1_valid_q <= !issue_done_q;
						if (!issue_done_q) begin
							if (idx_q == LAST_IDX) begin
								issue_done_q <= 1'b1;
							end else begin
								idx_q <= idx_q + 1'b1;
							end
						end else begin
							// final slot compared this cycle
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (rsp_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= req.opcode;
			key_light_q <= req.light_id;
			key_day_q   <= req.day;
			key_min_q   <= req.minute;
		end
		if (ram_re) begin
			idx_s1 <= idx_q;
		end

		// held response
		if (accept && id_bad && (req.opcode == OP_ON || req.opcode == OP_OFF)) begin
			pend_q <= '{kind: KIND_STATUS, status: ST_BAD, cmd_light: 7'd0,
				turn_on: 1'b0, last: 1'b1};
		end else if (state_q == ST_FIND && (find_free || idx_q == LAST_IDX)) begin
			pend_q <= '{kind: KIND_STATUS, status: (find_free ? ST_OK : ST_FULL),
				cmd_light: 7'd0, turn_on: 1'b0, last: 1'b1};
		end else if (tk_hit && scan_adv) begin
			pend_q <= '{kind: KIND_CMD, status: ST_OK, cmd_light: ent.light,
				turn_on: ent.turn_on, last: 1'b0};
		end

		// a command learns it is last only when the scan ends without a successor
		if (drain_push || succ_push) begin
			rsp_q <= '{kind: pend_q.kind, status: pend_q.status, cmd_light: pend_q.cmd_light,
				turn_on: pend_q.turn_on, last: drain_push};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// compare stage only lives inside a scan
	`WEST_ASSERT(a_s1_in_scan, clk, arst_n, s1_valid_q |-> (state_q == ST_SCAN),
		"ram read data live outside a scan")
	// nothing may be held back once the block takes a new request
	`WEST_NEVER(a_idle_pend, clk, arst_n, (state_q == ST_IDLE) && pend_valid_q,
		"response held while idle")
	// status responses are always the only and last one of their request
	`WEST_ASSERT(a_status_last, clk, arst_n,
		(rsp_valid_q && (rsp_q.kind == KIND_STATUS)) |-> rsp_q.last,
		"status response without last")
	// a slot write hands an ok status to the drain stage
	`WEST_ASSERT(a_write_status, clk, arst_n,
		ram_we |=> ((state_q == ST_DRAIN) && pend_valid_q && (pend_q.status == ST_OK)),
		"slot written without ok status")

endmodule

// ===== tb/tb_weekly_event_schedule_table.sv =====
// self-checking testbench of the weekly event schedule table: directed cases, then random traffic
// depends on west_pkg and weekly_event_schedule_table; checks responses against model or typed rows
`timescale 1ns / 100ps

module tb_weekly_event_schedule_table;
	import west_pkg::*;

	localparam int TABLE_DEPTH = 64;
	// cycles of quiet after the last owed response: a full scan plus margin
	localparam int DRAIN = TABLE_DEPTH + 16;
	// cycles with no transaction anywhere before the run is declared hung
	localparam int WATCHDOG = 5000;
	// length of the deliberate receiver hold-off
	localparam int LONG_HOLD = 300;
	localparam logic [2:0] LIMIT_ADDR = {REG_LIGHT_ID_LIMIT, 2'b00};

	// one request as queued for the sender, with an optional typed-in response
	typedef struct packed {
		west_req_t req;
		logic      typed;
		west_rsp_t want;
	} item_t;

	localparam west_rsp_t RSP_OK  = '{KIND_STATUS, ST_OK, 7'd0, 1'b0, 1'b1};
	localparam west_rsp_t RSP_BAD = '{KIND_STATUS, ST_BAD, 7'd0, 1'b0, 1'b1};
	localparam west_rsp_t NO_RSP  = '0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	west_req_t   req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	west_rsp_t   rsp;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	weekly_event_schedule_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// model copy of the schedule table and its register
	logic              slot_used   [TABLE_DEPTH];
	logic [6:0]        slot_light  [TABLE_DEPTH];
	logic [3:0]        slot_day    [TABLE_DEPTH];
	logic [10:0]       slot_minute [TABLE_DEPTH];
	logic              slot_on     [TABLE_DEPTH];
	logic [6:0]        id_limit = LIMIT_RESET;

	item_t     send_q[$];          // requests waiting for the sender
	item_t     on_bus = '0;        // request currently offered on the req channel
	west_rsp_t step_rsp_q[$];      // responses of the request just applied to the model
	west_rsp_t owed_rsp_q[$];      // responses the block still owes, oldest first
	west_req_t sched_hist[$];      // scheduled triples that a later remove may aim at

	bit offering = 1'b0;
	bit no_idle = 1'b0;
	bit long_hold_req = 1'b0;
	int errors = 0;
	int idle_cycles = 0;

	// minutes that ticks and schedules share, so that ticks find due entries
	logic [10:0] hot_min [5] = '{11'd0, 11'd1, 11'd720, 11'd1439, 11'd2047};

	// directed rows, run right after reset with the reset limit of 32
	localparam int DIR_ROWS = 25;
	item_t dir_tab [DIR_ROWS] = '{
		// tick on an empty table: nothing due
		'{'{OP_TICK,   8'sd0,    4'd0,  11'd0},    1'b0, NO_RSP},
		// negative ids and ids at or above the limit are refused
		'{'{OP_ON,     -8'sd128, 4'd0,  11'd0},    1'b1, RSP_BAD},
		'{'{OP_OFF,    -8'sd1,   4'd3,  11'd5},    1'b1, RSP_BAD},
		'{'{OP_ON,     8'sd32,   4'd1,  11'd2},    1'b1, RSP_BAD},
		'{'{OP_OFF,    8'sd127,  4'd15, 11'd2047}, 1'b1, RSP_BAD},
		// accepted schedules, field extremes and odd day codes among them
		'{'{OP_ON,     8'sd0,    4'd0,  11'd0},    1'b1, RSP_OK},
		'{'{OP_OFF,    8'sd31,   4'd7,  11'd1439}, 1'b1, RSP_OK},
		'{'{OP_ON,     8'sd5,    4'd8,  11'd600},  1'b1, RSP_OK},
		'{'{OP_OFF,    8'sd6,    4'd9,  11'd600},  1'b1, RSP_OK},
		'{'{OP_ON,     8'sd7,    4'd15, 11'd2047}, 1'b1, RSP_OK},
		// duplicate of an earlier entry
		'{'{OP_ON,     8'sd5,    4'd8,  11'd600},  1'b1, RSP_OK},
		'{'{OP_OFF,    8'sd9,    4'd12, 11'd1440}, 1'b1, RSP_OK},
		// ticks: id field ignored, weekday, weekend, exact odd codes, every day
		'{'{OP_TICK,   -8'sd128, 4'd0,  11'd0},    1'b0, NO_RSP},
		'{'{OP_TICK,   8'sd0,    4'd3,  11'd600},  1'b0, NO_RSP},
		'{'{OP_TICK,   8'sd0,    4'd6,  11'd600},  1'b0, NO_RSP},
		'{'{OP_TICK,   8'sd0,    4'd0,  11'd600},  1'b0, NO_RSP},
		'{'{OP_TICK,   8'sd0,    4'd15, 11'd2047}, 1'b0, NO_RSP},
		'{'{OP_TICK,   8'sd0,    4'd7,  11'd1439}, 1'b0, NO_RSP},
		'{'{OP_TICK,   8'sd0,    4'd12, 11'd1440}, 1'b0, NO_RSP},
		// tick day equal to the weekend code itself
		'{'{OP_TICK,   8'sd0,    4'd9,  11'd600},  1'b0, NO_RSP},
		// negative remove matches nothing, then both duplicates go at once
		'{'{OP_REMOVE, -8'sd1,   4'd8,  11'd600},  1'b0, NO_RSP},
		'{'{OP_REMOVE, 8'sd5,    4'd8,  11'd600},  1'b0, NO_RSP},
		'{'{OP_TICK,   8'sd0,    4'd3,  11'd600},  1'b0, NO_RSP},
		'{'{OP_REMOVE, 8'sd0,    4'd0,  11'd0},    1'b0, NO_RSP},
		'{'{OP_TICK,   8'sd127,  4'd0,  11'd0},    1'b0, NO_RSP}
	};

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
	end

	// does an entry day code cover today
	function automatic logic day_covers(input logic [3:0] code, input logic [3:0] today);
		if (code == DAY_EVERY || code == today) return 1'b1;
		if (code == DAY_WEEKEND && (today == DAY_SUNDAY || today == DAY_SATURDAY)) return 1'b1;
		if (code == DAY_WEEKDAYS && today >= DAY_MONDAY && today <= DAY_FRIDAY) return 1'b1;
		return 1'b0;
	endfunction

	// apply one accepted request to the model table, leaving its responses in step_rsp_q
	task automatic apply_request(input west_req_t r);
		west_rsp_t  o;
		logic [7:0] raw;
		int         free_slot;
		int         i;
		raw = r.light_id;
		o = '0;
		step_rsp_q.delete();
		case (r.opcode)
			OP_ON, OP_OFF: begin
				o.kind = KIND_STATUS;
				o.last = 1'b1;
				if (raw[7] || raw >= {1'b0, id_limit}) begin
					o.status = ST_BAD;
				end else begin
					// lowest free slot wins
					free_slot = -1;
					for (i = TABLE_DEPTH - 1; i >= 0; i--)
						if (!slot_used[i]) free_slot = i;
					if (free_slot < 0) begin
						o.status = ST_FULL;
					end else begin
						slot_used[free_slot]   = 1'b1;
						slot_light[free_slot]  = raw[6:0];
						slot_day[free_slot]    = r.day;
						slot_minute[free_slot] = r.minute;
						slot_on[free_slot]     = (r.opcode == OP_ON);
						o.status = ST_OK;
					end
				end
				step_rsp_q.push_back(o);
			end
			OP_REMOVE: begin
				if (!raw[7]) begin
					for (i = 0; i < TABLE_DEPTH; i++)
						if (slot_used[i] && slot_light[i] == raw[6:0] &&
								slot_day[i] == r.day && slot_minute[i] == r.minute)
							slot_used[i] = 1'b0;
				end
			end
			default: begin
				// minute tick: one command per due entry in slot order
				for (i = 0; i < TABLE_DEPTH; i++) begin
					if (slot_used[i] && day_covers(slot_day[i], r.day) &&
							slot_minute[i] == r.minute) begin
						o = '0;
						o.kind      = KIND_CMD;
						o.status    = ST_OK;
						o.cmd_light = slot_light[i];
						o.turn_on   = slot_on[i];
						step_rsp_q.push_back(o);
					end
				end
				if (step_rsp_q.size() > 0)
					step_rsp_q[step_rsp_q.size() - 1].last = 1'b1;
			end
		endcase
	endtask

	// compare one response transaction with the oldest owed one
	task automatic check_rsp(input west_rsp_t got);
		west_rsp_t want;
		if (owed_rsp_q.size() == 0) begin
			$error("response with nothing owed: %h", got);
			errors++;
		end else begin
			want = owed_rsp_q.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, actual %0d", want.kind, got.kind);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.cmd_light !== want.cmd_light) begin
				$error("cmd_light: expected %0d, actual %0d", want.cmd_light, got.cmd_light);
				errors++;
			end
			if (got.turn_on !== want.turn_on) begin
				$error("turn_on: expected %0d, actual %0d", want.turn_on, got.turn_on);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, actual %0d", want.last, got.last);
				errors++;
			end
		end
	endtask

	// both channels are observed at the rising edge, before the edge's updates land
	always @(posedge clk) begin : monitor
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				check_rsp(rsp);
				moved = 1'b1;
			end
			if (req_valid && !req_stall) begin
				apply_request(req);
				// typed rows carry their own answer, the model still tracks the table
				if (on_bus.typed)
					owed_rsp_q.push_back(on_bus.want);
				else
					foreach (step_rsp_q[k]) owed_rsp_q.push_back(step_rsp_q[k]);
				moved = 1'b1;
			end
			idle_cycles <= moved ? 0 : idle_cycles + 1;
		end
	end

	// sender: one request per transaction, random gaps between them
	initial begin : sender
		int    gap_left;
		item_t it;
		gap_left = 0;
		forever begin
			@(posedge clk);
			if (req_valid && !req_stall) offering = 1'b0;
			if (!offering && arst_n) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (send_q.size() > 0) begin
					it = send_q.pop_front();
					req       <= it.req;
					on_bus    <= it;
					req_valid <= 1'b1;
					offering = 1'b1;
					if (!no_idle && $urandom_range(0, 3) == 0)
						gap_left = $urandom_range(1, 19);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				hold_left = LONG_HOLD;
				long_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				hold_left = $urandom_range(1, 19) - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// hang detector: too long without any transaction
	initial begin : watchdog
		while (idle_cycles < WATCHDOG) @(posedge clk);
		$display("tb_weekly_event_schedule_table failed");
		$finish;
	end

	function automatic void queue_req(input logic [1:0] op, input logic [7:0] id,
			input logic [3:0] day, input logic [10:0] minute);
		item_t it;
		it = '0;
		it.req = '{op, id, day, minute};
		send_q.push_back(it);
	endfunction

	function automatic logic [10:0] pick_minute();
		if ($urandom_range(0, 4) != 0) return hot_min[$urandom_range(0, 4)];
		return 11'($urandom);
	endfunction

	// one random request: mostly well-formed schedule/remove/tick traffic, some raw noise
	task automatic queue_random_item();
		west_req_t r;
		item_t     it;
		int        p;
		int        k;
		r = '0;
		p = $urandom_range(0, 99);
		if (p < 35) begin
			r.opcode = $urandom_range(0, 1) ? OP_OFF : OP_ON;
			if (id_limit != 0 && $urandom_range(0, 99) < 85)
				r.light_id = 8'($urandom_range(0, id_limit - 1));
			else
				r.light_id = 8'($urandom);
			r.day = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 9))
				: 4'($urandom_range(10, 15));
			r.minute = pick_minute();
			if (!r.light_id[7]) sched_hist.push_back(r);
		end else if (p < 60) begin
			// remove aims at something scheduled before, most of the time
			if (sched_hist.size() > 0 && $urandom_range(0, 99) < 85) begin
				k = $urandom_range(0, sched_hist.size() - 1);
				r = sched_hist[k];
				sched_hist.delete(k);
			end else begin
				r.light_id = 8'($urandom);
				r.day = 4'($urandom_range(0, 15));
				r.minute = pick_minute();
			end
			r.opcode = OP_REMOVE;
		end else if (p < 90) begin
			r.opcode = OP_TICK;
			r.light_id = 8'($urandom);
			r.day = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(0, 6))
				: 4'($urandom_range(7, 15));
			r.minute = pick_minute();
		end else begin
			r = west_req_t'(25'($urandom));
		end
		it = '0;
		it.req = r;
		send_q.push_back(it);
	endtask

	// register write with a setup phase and an access phase, then a read back
	task automatic set_limit(input logic [6:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= LIMIT_ADDR;
		pwdata  <= {25'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		id_limit = v;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[6:0] !== v) begin
			$error("light_id_limit: expected %0d, actual %0d", v, prdata[6:0]);
			errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// wait until everything queued is sent and answered, then let a scan run out
	task automatic settle();
		while (send_q.size() > 0 || offering || owed_rsp_q.size() > 0) @(negedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic run_random(input int n, input logic [6:0] lim, input bit hold, input bit quiet);
		set_limit(lim);
		no_idle = quiet;
		for (int k = 0; k < n; k++) queue_random_item();
		// receiver sits still while the sender keeps offering, so the block backs up
		if (hold) long_hold_req = 1'b1;
		settle();
	endtask

	initial begin : main
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed rows against the reset limit
		foreach (dir_tab[k]) send_q.push_back(dir_tab[k]);
		settle();

		// limit zero refuses every schedule; a tick still works
		set_limit(7'd0);
		queue_req(OP_ON, 8'd0, 4'd0, 11'd0);
		queue_req(OP_OFF, 8'd5, 4'd7, 11'd100);
		queue_req(OP_TICK, 8'd0, 4'd2, 11'd1439);
		settle();

		// top limit: id 126 passes, 127 does not; then fill the table past full
		set_limit(7'd127);
		queue_req(OP_ON, 8'd126, 4'd7, 11'd100);
		queue_req(OP_OFF, 8'd127, 4'd7, 11'd100);
		for (int k = 0; k < TABLE_DEPTH + 2; k++)
			queue_req((k % 2) ? OP_OFF : OP_ON, 8'(k % 4), 4'd7, 11'd100);
		// one tick makes the largest burst of commands
		queue_req(OP_TICK, 8'd0, 4'd2, 11'd100);
		for (int k = 0; k < 4; k++) queue_req(OP_REMOVE, 8'(k), 4'd7, 11'd100);
		queue_req(OP_REMOVE, 8'd126, 4'd7, 11'd100);
		queue_req(OP_TICK, 8'd0, 4'd2, 11'd100);
		queue_req(OP_ON, 8'd20, 4'd8, 11'd1);
		settle();

		// random traffic over several limits; lowering to 10 keeps higher ids stored
		run_random(50, LIMIT_RESET, 1'b0, 1'b0);
		run_random(30, 7'd1, 1'b0, 1'b0);
		run_random(50, 7'($urandom_range(1, 127)), 1'b1, 1'b0);
		run_random(40, 7'd10, 1'b0, 1'b0);
		// closing stretch without any idling
		run_random(30, 7'd127, 1'b0, 1'b1);

		if (owed_rsp_q.size() != 0) begin
			$error("responses never seen: %0d", owed_rsp_q.size());
			errors++;
		end
		if (errors == 0)
			$display("tb_weekly_event_schedule_table passed");
		else
			$display("tb_weekly_event_schedule_table failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/west_pkg.sv
rtl/west_ram.sv
rtl/weekly_event_schedule_table.sv
tb/tb_weekly_event_schedule_table.sv
